// File: hdl/fgs_pkg.sv
// Shared types, codes and helpers for the bit-parallel fault gate simulator.
// Depends on nothing; the top level, fgs_gate_unit and fgs_epoch_ctrl refer to it by scoped names.
package fgs_pkg;

  localparam int unsigned NET_COUNT_DEF    = 4096;
  localparam int unsigned PATTERN_BITS_DEF = 64;
  localparam int unsigned SRC_W            = 12;
  localparam int unsigned WORD_W           = 64;
  localparam int unsigned EPOCH_W          = 8;
  localparam int unsigned IDX_MAX_W        = 17;

  localparam int unsigned S_TDATA_W = 104;
  localparam int unsigned S_TUSER_W = 5;
  localparam int unsigned M_TDATA_W = 192;
  localparam int unsigned M_TUSER_W = 1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SET   = 2'd1,
    CMD_EVAL  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    G_INV  = 3'd0,
    G_AND  = 3'd1,
    G_OR   = 3'd2,
    G_NAND = 3'd3,
    G_NOR  = 3'd4,
    G_XOR  = 3'd5,
    G_BUF  = 3'd6,
    G_XNOR = 3'd7
  } gate_e;

  typedef enum logic {
    ST_SWEEP = 1'b0,
    ST_RUN   = 1'b1
  } sweep_state_e;

  typedef struct packed {
    logic               sweeping;
    logic               last;
    logic [EPOCH_W-1:0] epoch;
  } epoch_stat_t;

  // Index wrap by a constant net count: restoring subtraction of n << j.
  function automatic logic [IDX_MAX_W-1:0] net_wrap(logic [SRC_W-1:0] raw,
                                                    int unsigned n);
    logic [31:0] r;
    logic [31:0] m;
    r = 32'(raw);
    for (int j = SRC_W - 1; j >= 0; j--) begin
      m = 32'(n) << j;
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[IDX_MAX_W-1:0];
  endfunction

endpackage

// File: hdl/bitparallel_fault_gate_sim.sv
// Top level of the bit-parallel fault gate simulator: accept stage, net store
// reads, evaluate/write-back stage with forwarding, and output register.
// Depends on fgs_pkg, fgs_net_ram, fgs_gate_unit and fgs_epoch_ctrl.
//
//   channel  | bus              | fields (low bit up)
//   ---------+------------------+-------------------------------------------
//   in       | s_axis_tdata     | first_source, second_source, target,
//            |                  | data_word, zero pad
//   in       | s_axis_tuser     | command, gate_type
//   out      | m_axis_tdata     | good_word, faulty_word, mismatch_word
//   out      | m_axis_tuser     | operand_missing
//
// One transfer per cycle sustained while m_axis is ready and no sweep runs. The
// store is read and the evaluate stage loaded on accept; evaluation, write back
// and the output register follow. A gate reading the previous gate's target
// takes it from a forwarding register, as the store read does not see that write.
// After reset, and on every 255th clear, a sweep over all NET_COUNT nets retags
// the store; s_axis_tready stays low for its length.
// Output stalls back up through the evaluate stage into s_axis_tready.
module bitparallel_fault_gate_sim #(
  parameter int unsigned NET_COUNT    = fgs_pkg::NET_COUNT_DEF,
  parameter int unsigned PATTERN_BITS = fgs_pkg::PATTERN_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // first_source[11:0], second_source[23:12], target[35:24], data_word[99:36]
  input  logic [fgs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // command[1:0], gate_type[4:2]
  input  logic [fgs_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // good_word[63:0], faulty_word[127:64], mismatch_word[191:128]
  output logic [fgs_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // operand_missing[0]
  output logic [fgs_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

  localparam int unsigned NET_W  = $clog2(NET_COUNT);
  localparam int unsigned PB     = PATTERN_BITS;
  localparam int unsigned W      = fgs_pkg::EPOCH_W + 2 * PB;
  localparam int unsigned SW     = fgs_pkg::SRC_W;
  localparam int unsigned WW     = fgs_pkg::WORD_W;

  // input unpacking
  fgs_pkg::cmd_e   in_cmd;
  fgs_pkg::gate_e  in_kind;
  logic [SW-1:0]   in_s1_raw, in_s2_raw, in_t_raw;
  logic [fgs_pkg::IDX_MAX_W-1:0] s1_wr, s2_wr, t_wr;
  logic [NET_W-1:0] in_s1, in_s2, in_t, in_a0;
  logic            accept;

  assign in_cmd    = fgs_pkg::cmd_e'(s_axis_tuser[1:0]);
  assign in_kind   = fgs_pkg::gate_e'(s_axis_tuser[4:2]);
  assign in_s1_raw = s_axis_tdata[SW-1:0];
  assign in_s2_raw = s_axis_tdata[2*SW-1:SW];
  assign in_t_raw  = s_axis_tdata[3*SW-1:2*SW];
  assign s1_wr     = fgs_pkg::net_wrap(in_s1_raw, NET_COUNT);
  assign s2_wr     = fgs_pkg::net_wrap(in_s2_raw, NET_COUNT);
  assign t_wr      = fgs_pkg::net_wrap(in_t_raw, NET_COUNT);
  assign in_s1     = s1_wr[NET_W-1:0];
  assign in_s2     = s2_wr[NET_W-1:0];
  assign in_t      = t_wr[NET_W-1:0];
  assign in_a0     = (in_cmd == fgs_pkg::CMD_READ) ? in_t : in_s1;

  // evaluate stage
  logic            b_valid_q;
  fgs_pkg::cmd_e   b_cmd_q;
  fgs_pkg::gate_e  b_kind_q;
  logic [NET_W-1:0] b_a0_q, b_a1_q, b_t_q;
  logic [PB-1:0]   b_data_q;

  logic            fwd_valid_q;
  logic [NET_W-1:0] fwd_addr_q;
  logic [W-1:0]    fwd_word_q;

  logic            out_valid_q;
  logic [PB-1:0]   out_good_q, out_faulty_q;
  logic            out_miss_q;

  fgs_pkg::epoch_stat_t stat;
  logic            sweep_we;
  logic [NET_W-1:0] sweep_addr;

  logic [W-1:0]    rd0, rd1, w0, w1;
  logic            v0, v1, single, b_adv, b_write, b_clear;
  logic [PB-1:0]   ga, gb, fa, fb, gate_good, gate_faulty;
  logic [PB-1:0]   res_good, res_faulty;
  logic            res_miss;
  logic            ram_we;
  logic [NET_W-1:0] ram_wa;
  logic [W-1:0]    ram_wd;

  assign b_adv   = b_valid_q && !stat.sweeping && (!out_valid_q || m_axis_tready);
  assign b_clear = b_adv && (b_cmd_q == fgs_pkg::CMD_CLEAR);
  assign b_write = b_adv && ((b_cmd_q == fgs_pkg::CMD_SET) || (b_cmd_q == fgs_pkg::CMD_EVAL));

  // no accept beside a wrapping clear: the sweep must precede every read
  assign s_axis_tready = !stat.sweeping
                         && (!b_valid_q || (b_adv && !(b_clear && stat.last)));
  assign accept = s_axis_tvalid && s_axis_tready;

  fgs_epoch_ctrl #(
    .NET_COUNT(NET_COUNT)
  ) u_epoch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (b_clear),
    .stat_o      (stat),
    .sweep_we_o  (sweep_we),
    .sweep_addr_o(sweep_addr)
  );

  assign ram_we = sweep_we || b_write;
  assign ram_wa = sweep_we ? sweep_addr : b_t_q;
  assign ram_wd = sweep_we ? W'(0) : {stat.epoch, res_good, res_faulty};

  fgs_net_ram #(
    .DEPTH(NET_COUNT),
    .WIDTH(W)
  ) u_ram (
    .clk_i (clk_i),
    .re_i  (accept),
    .ra0_i (in_a0),
    .ra1_i (in_s2),
    .rd0_o (rd0),
    .rd1_o (rd1),
    .we_i  (ram_we),
    .wa_i  (ram_wa),
    .wd_i  (ram_wd)
  );

  assign w0 = (fwd_valid_q && (fwd_addr_q == b_a0_q)) ? fwd_word_q : rd0;
  assign w1 = (fwd_valid_q && (fwd_addr_q == b_a1_q)) ? fwd_word_q : rd1;
  assign v0 = (w0[W-1:2*PB] == stat.epoch);
  assign v1 = (w1[W-1:2*PB] == stat.epoch);
  assign ga = v0 ? w0[2*PB-1:PB] : '0;
  assign fa = v0 ? w0[PB-1:0]    : '0;
  assign single = (b_kind_q == fgs_pkg::G_INV) || (b_kind_q == fgs_pkg::G_BUF);
  assign gb = (v1 && !single) ? w1[2*PB-1:PB] : '0;
  assign fb = (v1 && !single) ? w1[PB-1:0]    : '0;

  fgs_gate_unit #(
    .PATTERN_BITS(PB)
  ) u_gate (
    .kind_i    (b_kind_q),
    .good_a_i  (ga),
    .good_b_i  (gb),
    .faulty_a_i(fa),
    .faulty_b_i(fb),
    .mask_i    (b_data_q),
    .good_o    (gate_good),
    .faulty_o  (gate_faulty)
  );

  always_comb begin
    res_good   = '0;
    res_faulty = '0;
    res_miss   = 1'b0;
    case (b_cmd_q)
      fgs_pkg::CMD_CLEAR: begin
        res_good   = '0;
        res_faulty = '0;
      end
      fgs_pkg::CMD_SET: begin
        res_good   = b_data_q;
        res_faulty = b_data_q;
      end
      fgs_pkg::CMD_EVAL: begin
        res_good   = gate_good;
        res_faulty = gate_faulty;
        res_miss   = !v0 || (!single && !v1);
      end
      default: begin
        res_good   = ga;
        res_faulty = fa;
      end
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (accept || b_adv) begin
        fwd_valid_q <= accept && b_write;
      end
      if (b_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_cmd_q  <= in_cmd;
      b_kind_q <= in_kind;
      b_a0_q   <= in_a0;
      b_a1_q   <= in_s2;
      b_t_q    <= in_t;
      b_data_q <= s_axis_tdata[3*SW+PB-1:3*SW];
    end
    if (b_write) begin
      fwd_addr_q <= b_t_q;
      fwd_word_q <= {stat.epoch, res_good, res_faulty};
    end
    if (b_adv) begin
      out_good_q   <= res_good;
      out_faulty_q <= res_faulty;
      out_miss_q   <= res_miss;
    end
  end

  assign m_axis_tvalid           = out_valid_q;
  assign m_axis_tdata[WW-1:0]    = WW'(out_good_q);
  assign m_axis_tdata[2*WW-1:WW] = WW'(out_faulty_q);
  assign m_axis_tdata[3*WW-1:2*WW] = WW'(out_good_q ^ out_faulty_q);
  assign m_axis_tuser[0]         = out_miss_q;

`ifndef ASSERT_OFF
  a_no_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(b_adv && stat.sweeping))
    else $error("evaluate stage wrote the net store during a sweep");

  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.epoch != '0)
    else $error("epoch zero would match swept tags");

  a_fwd_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_valid_q |-> b_valid_q)
    else $error("forwarding register live with no item in the evaluate stage");

  a_wrap_blocks_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_clear && stat.last) |=> (stat.sweeping && !b_valid_q))
    else $error("transfer accepted across an epoch wrap");
`endif

endmodule

// File: hdl/fgs_net_ram.sv
// Net store: one word per net holding {epoch tag, good word, faulty word}.
// Two synchronous read ports, one write port. Uses nothing from fgs_pkg.
module fgs_net_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 136
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] ra0_i,
  input  logic [$clog2(DEPTH)-1:0] ra1_i,
  output logic [WIDTH-1:0]         rd0_o,
  output logic [WIDTH-1:0]         rd1_o,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wa_i,
  input  logic [WIDTH-1:0]         wd_i
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd0_o <= mem[ra0_i];
      rd1_o <= mem[ra1_i];
    end
  end

endmodule

// File: hdl/fgs_gate_unit.sv
// Gate evaluator: applies one gate to the good and faulty operand words and
// injects the failure mask on the faulty output of every gate but BUF. Depends on fgs_pkg.
module fgs_gate_unit #(
  parameter int unsigned PATTERN_BITS = 64
) (
  input  fgs_pkg::gate_e          kind_i,
  input  logic [PATTERN_BITS-1:0] good_a_i,
  input  logic [PATTERN_BITS-1:0] good_b_i,
  input  logic [PATTERN_BITS-1:0] faulty_a_i,
  input  logic [PATTERN_BITS-1:0] faulty_b_i,
  input  logic [PATTERN_BITS-1:0] mask_i,
  output logic [PATTERN_BITS-1:0] good_o,
  output logic [PATTERN_BITS-1:0] faulty_o
);

  logic [PATTERN_BITS-1:0] faulty_raw;

  always_comb begin
    case (kind_i)
      fgs_pkg::G_INV: begin
        good_o     = ~good_a_i;
        faulty_raw = ~faulty_a_i;
      end
      fgs_pkg::G_AND: begin
        good_o     = good_a_i & good_b_i;
        faulty_raw = faulty_a_i & faulty_b_i;
      end
      fgs_pkg::G_OR: begin
        good_o     = good_a_i | good_b_i;
        faulty_raw = faulty_a_i | faulty_b_i;
      end
      fgs_pkg::G_NAND: begin
        good_o     = ~(good_a_i & good_b_i);
        faulty_raw = ~(faulty_a_i & faulty_b_i);
      end
      fgs_pkg::G_NOR: begin
        good_o     = ~(good_a_i | good_b_i);
        faulty_raw = ~(faulty_a_i | faulty_b_i);
      end
      fgs_pkg::G_XOR: begin
        good_o     = good_a_i ^ good_b_i;
        faulty_raw = faulty_a_i ^ faulty_b_i;
      end
      fgs_pkg::G_BUF: begin
        good_o     = good_a_i;
        faulty_raw = faulty_a_i;
      end
      default: begin
        good_o     = ~(good_a_i ^ good_b_i);
        faulty_raw = ~(faulty_a_i ^ faulty_b_i);
      end
    endcase
  end

  // BUF cells carry no failures
  assign faulty_o = (kind_i == fgs_pkg::G_BUF) ? faulty_raw : (faulty_raw ^ mask_i);

endmodule

// File: hdl/fgs_epoch_ctrl.sv
// Written-flag epochs: a net is written when its stored tag equals the
// current epoch. Sweeps all tags to zero after reset and on epoch wrap.
// Depends on fgs_pkg.
module fgs_epoch_ctrl #(
  parameter int unsigned NET_COUNT = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  output fgs_pkg::epoch_stat_t         stat_o,
  output logic                         sweep_we_o,
  output logic [$clog2(NET_COUNT)-1:0] sweep_addr_o
);

  localparam int unsigned NET_W = $clog2(NET_COUNT);
  localparam logic [fgs_pkg::EPOCH_W-1:0] EPOCH_FIRST = fgs_pkg::EPOCH_W'(1);
  localparam logic [fgs_pkg::EPOCH_W-1:0] EPOCH_LAST  = '1;

  fgs_pkg::sweep_state_e        state_q, state_d;
  logic [NET_W-1:0]             cnt_q, cnt_d;
  logic [fgs_pkg::EPOCH_W-1:0]  epoch_q, epoch_d;
  logic                         sweep_done;

  assign sweep_done = (cnt_q == NET_W'(NET_COUNT - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    epoch_d = epoch_q;
    case (state_q)
      fgs_pkg::ST_SWEEP: begin
        cnt_d = cnt_q + NET_W'(1);
        if (sweep_done) begin
          state_d = fgs_pkg::ST_RUN;
        end
      end
      fgs_pkg::ST_RUN: begin
        if (clear_i) begin
          if (epoch_q == EPOCH_LAST) begin
            epoch_d = EPOCH_FIRST;
            cnt_d   = '0;
            state_d = fgs_pkg::ST_SWEEP;
          end else begin
            epoch_d = epoch_q + fgs_pkg::EPOCH_W'(1);
          end
        end
      end
      default: begin
        state_d = fgs_pkg::ST_SWEEP;
        cnt_d   = '0;
      end
    endcase
  end

  always_comb begin
    stat_o.sweeping = (state_q == fgs_pkg::ST_SWEEP);
    stat_o.last     = (epoch_q == EPOCH_LAST);
    stat_o.epoch    = epoch_q;
    sweep_we_o      = (state_q == fgs_pkg::ST_SWEEP);
    sweep_addr_o    = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fgs_pkg::ST_SWEEP;
      cnt_q   <= '0;
      epoch_q <= EPOCH_FIRST;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      epoch_q <= epoch_d;
    end
  end

endmodule
